// ===== hw/rtl/krrm_pkg.sv =====
// ----------------------------------------------------------------------------
// krrm_pkg
// Shared types, register indexes, request codes and usage constants for the
// keyboard report remap/merge core.
// ----------------------------------------------------------------------------
`default_nettype none

package krrm_pkg;

  // Defaults for the top-level parameters
  localparam int REPORT_BYTES_DEF = 8;
  localparam int PT_ENTRIES_DEF   = 8;
  localparam int OV_ENTRIES_DEF   = 8;

  // Fixed field widths
  localparam int MOD_BITS   = 8;
  localparam int KEY_BYTES  = 6;
  localparam int CFG_W      = 64;
  localparam int CFG_IDX_W  = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PROFILE_ENABLED   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SWAP_EN           = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PASSTHROUGH_LIST  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PT_COUNT          = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OVERRIDE_LOW      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OVERRIDE_HIGH     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OV_COUNT          = 3'd6;

  // Request types
  localparam logic [1:0] REQ_COPY    = 2'd0;
  localparam logic [1:0] REQ_PREPARE = 2'd1;
  localparam logic [1:0] REQ_MERGE   = 2'd2;

  // HID usages
  localparam logic [7:0] USAGE_LCTRL   = 8'he0;
  localparam logic [7:0] USAGE_LGUI    = 8'he3;
  localparam logic [7:0] USAGE_RCTRL   = 8'he4;
  localparam logic [7:0] USAGE_RGUI    = 8'he7;
  localparam logic [7:0] USAGE_ERR_MAX = 8'h03;

  typedef struct packed {
    logic         profile_enabled;
    logic         swap_en;
    logic [63:0]  passthrough_list;
    logic [3:0]   pt_count;
    logic [127:0] override_pairs;     // {high, low}
    logic [3:0]   ov_count;
  } cfg_t;

  // One insertion into the report builder
  typedef struct packed {
    logic       valid;
    logic       raw;     // synthesized key: no modifier decode, always dedup
    logic [7:0] usage;
  } slot_op_t;

endpackage

`default_nettype wire

// ===== hw/rtl/krrm_remap.sv =====
// ----------------------------------------------------------------------------
// krrm_remap
// Usage remap unit: passthrough list, then first override, then ctrl/gui swap.
// ----------------------------------------------------------------------------
`default_nettype none

module krrm_remap #(
  parameter int PT_ENTRIES = krrm_pkg::PT_ENTRIES_DEF,
  parameter int OV_ENTRIES = krrm_pkg::OV_ENTRIES_DEF
) (
  input  krrm_pkg::cfg_t cfg,
  input  logic [7:0]     usage,
  output logic [7:0]     mapped
);
  import krrm_pkg::*;

  logic [3:0] pt_lim;
  logic [3:0] ov_lim;
  logic       pt_hit;
  logic       ov_hit;
  logic [7:0] ov_to;
  logic [7:0] swapped;

  // Saturate counts at table capacity
  assign pt_lim = (cfg.pt_count > 4'(PT_ENTRIES)) ? 4'(PT_ENTRIES)
                                                 : cfg.pt_count;
  assign ov_lim = (cfg.ov_count > 4'(OV_ENTRIES)) ? 4'(OV_ENTRIES)
                                                 : cfg.ov_count;

  always_comb begin
    pt_hit = 1'b0;
    for (int i = 0; i < PT_ENTRIES; i++) begin
      if ((4'(i) < pt_lim) && (cfg.passthrough_list[8*i +: 8] == usage)) begin
        pt_hit = 1'b1;
      end
    end
  end

  // Scan from the top so the lowest matching entry wins
  always_comb begin
    ov_hit = 1'b0;
    ov_to  = 8'h00;
    for (int i = OV_ENTRIES - 1; i >= 0; i--) begin
      if ((4'(i) < ov_lim) && (cfg.override_pairs[16*i +: 8] == usage)) begin
        ov_hit = 1'b1;
        ov_to  = cfg.override_pairs[16*i+8 +: 8];
      end
    end
  end

  always_comb begin
    case (usage)
      USAGE_LCTRL: swapped = USAGE_LGUI;
      USAGE_LGUI:  swapped = USAGE_LCTRL;
      USAGE_RCTRL: swapped = USAGE_RGUI;
      USAGE_RGUI:  swapped = USAGE_RCTRL;
      default:     swapped = usage;
    endcase
  end

  always_comb begin
    if (cfg.profile_enabled && pt_hit) begin
      mapped = usage;
    end else if (cfg.profile_enabled && ov_hit) begin
      mapped = ov_to;
    end else if (cfg.swap_en) begin
      mapped = swapped;
    end else begin
      mapped = usage;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/krrm_build.sv =====
// ----------------------------------------------------------------------------
// krrm_build
// Report builder: modifier byte and key slots, one insertion per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module krrm_build #(
  parameter int SLOT_COUNT = krrm_pkg::REPORT_BYTES_DEF - 2
) (
  input  logic                      clk,
  input  logic                      clear,
  input  krrm_pkg::slot_op_t        op,
  output logic [7:0]                mods_next,
  output logic [8*SLOT_COUNT-1:0]   keys_next
);
  import krrm_pkg::*;

  logic [7:0]            slots      [SLOT_COUNT];
  logic [7:0]            slots_next [SLOT_COUNT];
  logic [7:0]            mods;
  logic [SLOT_COUNT-1:0] free_sel;
  logic                  free_seen;
  logic                  has_key;
  logic                  is_mod;
  logic                  do_place;

  always_comb begin
    has_key   = 1'b0;
    free_seen = 1'b0;
    free_sel  = '0;
    for (int k = 0; k < SLOT_COUNT; k++) begin
      if (slots[k] == op.usage) begin
        has_key = 1'b1;
      end
      free_sel[k] = (slots[k] == 8'h00) && !free_seen;
      free_seen   = free_seen || (slots[k] == 8'h00);
    end
  end

  assign is_mod = !op.raw && (op.usage >= USAGE_LCTRL) && (op.usage <= USAGE_RGUI);

  // Drop zero and duplicates; error usages may repeat unless synthesized
  assign do_place = op.valid && (op.usage != 8'h00) && !is_mod &&
                    !(has_key && (op.raw || (op.usage > USAGE_ERR_MAX)));

  always_comb begin
    if (clear) begin
      mods_next = 8'h00;
    end else if (op.valid && is_mod) begin
      mods_next = mods | (8'h01 << op.usage[2:0]);
    end else begin
      mods_next = mods;
    end
    for (int k = 0; k < SLOT_COUNT; k++) begin
      if (clear) begin
        slots_next[k] = 8'h00;
      end else if (do_place && free_sel[k]) begin
        slots_next[k] = op.usage;
      end else begin
        slots_next[k] = slots[k];
      end
      keys_next[8*k +: 8] = slots_next[k];
    end
  end

  always_ff @(posedge clk) begin
    mods <= mods_next;
    for (int k = 0; k < SLOT_COUNT; k++) begin
      slots[k] <= slots_next[k];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/keyboard_report_remap_merge_core.sv =====
// ----------------------------------------------------------------------------
// keyboard_report_remap_merge_core
// Rebuilds a boot-keyboard report: copy, prepare (remap) or merge with a
// synthesized report.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                                         Handshake
//  --------  ----------------------------------------------  -------------------
//  request   req_type, phys_*, synth_*                       start && !busy
//  result    out_modifiers, out_reserved, out_keys           done (one cycle)
//  config    wr_index, wr_data                               wr_en
//
//  Copy requests strobe done in the cycle after acceptance.
//  Prepare and merge walk the modifier bits, then the physical slots (merge
//  then adds the synthesized slots): one usage per cycle through the shared remap
//  and slot-insert unit. busy is high for the whole run.
//  rst is synchronous and clears control state and the configuration.
//  The receiver cannot stall: each result word is valid only while done is high.
// ----------------------------------------------------------------------------
`default_nettype none

module keyboard_report_remap_merge_core #(
  parameter int REPORT_BYTES = krrm_pkg::REPORT_BYTES_DEF,
  parameter int PT_ENTRIES   = krrm_pkg::PT_ENTRIES_DEF,
  parameter int OV_ENTRIES   = krrm_pkg::OV_ENTRIES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        req_type,
  input  logic [krrm_pkg::MOD_BITS-1:0]     phys_modifiers,
  input  logic [7:0]                        phys_reserved,
  input  logic [8*krrm_pkg::KEY_BYTES-1:0]  phys_keys,
  input  logic [krrm_pkg::MOD_BITS-1:0]     synth_modifiers,
  input  logic [8*krrm_pkg::KEY_BYTES-1:0]  synth_keys,
  input  logic                              wr_en,
  input  logic [krrm_pkg::CFG_IDX_W-1:0]    wr_index,
  input  logic [krrm_pkg::CFG_W-1:0]        wr_data,
  output logic                              done,
  output logic [krrm_pkg::MOD_BITS-1:0]     out_modifiers,
  output logic [7:0]                        out_reserved,
  output logic [8*krrm_pkg::KEY_BYTES-1:0]  out_keys
);
  import krrm_pkg::*;

  localparam int SLOT_COUNT = REPORT_BYTES - 2;
  localparam int LAST_PREP  = MOD_BITS + SLOT_COUNT - 1;
  localparam int LAST_MERGE = MOD_BITS + 2 * SLOT_COUNT - 1;
  localparam int STEP_W     = $clog2(LAST_MERGE + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  cfg_t                    cfg;
  logic                    state;
  logic [STEP_W-1:0]       step;
  logic [STEP_W-1:0]       last_step;
  logic                    merge;
  logic [MOD_BITS-1:0]     pmods;
  logic [7:0]              pres;
  logic [8*SLOT_COUNT-1:0] pkeys;
  logic [MOD_BITS-1:0]     smods;
  logic [8*SLOT_COUNT-1:0] skeys;

  logic                    accept;
  logic                    is_copy;
  logic                    at_last;
  logic [7:0]              sel_usage;
  logic                    sel_raw;
  logic                    sel_valid;
  logic [7:0]              mapped;
  slot_op_t                op;
  logic [7:0]              mods_next;
  logic [8*SLOT_COUNT-1:0] keys_next;

  assign busy    = (state == ST_RUN);
  assign accept  = start && !busy;
  // Unknown request type behaves as copy
  assign is_copy = !((req_type == REQ_PREPARE) || (req_type == REQ_MERGE));
  assign last_step = merge ? STEP_W'(LAST_MERGE) : STEP_W'(LAST_PREP);
  assign at_last   = (step == last_step);

  // Configuration writes; indexes past the list are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_PROFILE_ENABLED:   cfg.profile_enabled   <= wr_data[0];
        REG_SWAP_EN:           cfg.swap_en           <= wr_data[0];
        REG_PASSTHROUGH_LIST:  cfg.passthrough_list  <= wr_data;
        REG_PT_COUNT:          cfg.pt_count          <= wr_data[3:0];
        REG_OVERRIDE_LOW:      cfg.override_pairs[63:0]   <= wr_data;
        REG_OVERRIDE_HIGH:     cfg.override_pairs[127:64] <= wr_data;
        REG_OV_COUNT:          cfg.ov_count          <= wr_data[3:0];
        default: ;
      endcase
    end
  end

  // Sequencer: modifier bits, then physical slots, then synthesized slots on merge
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (accept) begin
        step <= '0;
        if (is_copy) begin
          done <= 1'b1;
        end else begin
          state <= ST_RUN;
        end
      end else if (state == ST_RUN) begin
        if (at_last) begin
          state <= ST_IDLE;
          done  <= 1'b1;
        end else begin
          step <= step + 1'b1;
        end
      end
    end
  end

  // Hold the request payload for the run
  always_ff @(posedge clk) begin
    if (accept) begin
      merge <= (req_type == REQ_MERGE);
      pmods <= phys_modifiers;
      pres  <= phys_reserved;
      pkeys <= phys_keys[8*SLOT_COUNT-1:0];
      smods <= synth_modifiers;
      skeys <= synth_keys[8*SLOT_COUNT-1:0];
    end
  end

  // Pick the usage for this step
  always_comb begin
    sel_usage = USAGE_LCTRL | {5'b00000, step[2:0]};
    sel_raw   = 1'b0;
    sel_valid = (state == ST_RUN) && pmods[step[2:0]];
    if (step >= STEP_W'(MOD_BITS)) begin
      sel_valid = (state == ST_RUN);
      sel_raw   = (step >= STEP_W'(MOD_BITS + SLOT_COUNT));
      for (int k = 0; k < SLOT_COUNT; k++) begin
        if (step == STEP_W'(MOD_BITS + k)) begin
          sel_usage = pkeys[8*k +: 8];
        end
        if (step == STEP_W'(MOD_BITS + SLOT_COUNT + k)) begin
          sel_usage = skeys[8*k +: 8];
        end
      end
    end
  end

  krrm_remap #(
    .PT_ENTRIES (PT_ENTRIES),
    .OV_ENTRIES (OV_ENTRIES)
  ) u_remap (
    .cfg    (cfg),
    .usage  (sel_usage),
    .mapped (mapped)
  );

  // Synthesized keys bypass the remap
  assign op.valid = sel_valid;
  assign op.raw   = sel_raw;
  assign op.usage = sel_raw ? sel_usage : mapped;

  krrm_build #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_build (
    .clk       (clk),
    .clear     (accept),
    .op        (op),
    .mods_next (mods_next),
    .keys_next (keys_next)
  );

  // Result word: copy loads straight from the request, a run loads at its end
  always_ff @(posedge clk) begin
    if (accept && is_copy) begin
      out_modifiers <= phys_modifiers;
      out_reserved  <= phys_reserved;
      out_keys      <= (8*KEY_BYTES)'(phys_keys[8*SLOT_COUNT-1:0]);
    end else if ((state == ST_RUN) && at_last) begin
      out_modifiers <= mods_next | (merge ? smods : 8'h00);
      out_reserved  <= pres;
      out_keys      <= (8*KEY_BYTES)'(keys_next);
    end
  end

`ifndef SYNTHESIS
  a_step_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (step <= last_step))
    else $error("step counter ran past the last step");

  a_run_ends_with_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |=> ((state == ST_RUN) || done))
    else $error("run left without a result strobe");

  a_done_source: assert property (@(posedge clk) disable iff (rst)
    $rose(done) |-> $past((accept && is_copy) || ((state == ST_RUN) && at_last)))
    else $error("result strobe without a finished request");
`endif

endmodule

`default_nettype wire
